// ===== hw/rtl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the circuit slot table
// Command codes, controller states, the request token that walks the slot
// chain, and default sizes.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int CMD_W     = 2;
  localparam int ID_W      = 64;
  localparam int DEF_SLOTS = 16;

  // id 0 is reserved, so the generator starts one above it
  localparam logic [ID_W-1:0] ID_FIRST = 64'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_COUNT  = 2'd3
  } cst_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } cst_state_t;

  // control part of the request as it passes from cell to cell
  typedef struct packed {
    logic     vld;
    cst_cmd_t cmd;
    logic     found;
  } cst_tok_t;

endpackage

// ===== hw/rtl/cst_cell.sv =====
// ----------------------------------------------------------------------------
// cst_cell: one slot of the circuit slot table
// Holds a valid mark and an id. Claims the request passing through if it is
// the first slot to qualify, applies the command, and hands the request on.
// ----------------------------------------------------------------------------
module cst_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cst_pkg::cst_tok_t         tok_in,
  input  logic [cst_pkg::ID_W-1:0]  key_in,
  input  logic [IDX_W-1:0]          idx_in,
  output cst_pkg::cst_tok_t         tok_out,
  output logic [cst_pkg::ID_W-1:0]  key_out,
  output logic [IDX_W-1:0]          idx_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                     valid_r, valid_nxt;
  logic [cst_pkg::ID_W-1:0] id_r, id_nxt;
  cst_pkg::cst_tok_t        tok_r, tok_nxt;
  logic [cst_pkg::ID_W-1:0] key_r;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     qualify;
  logic                     hit;

  always_comb begin
    unique case (tok_in.cmd)
      cst_pkg::CMD_ALLOC:  qualify = !valid_r;
      cst_pkg::CMD_LOOKUP: qualify = valid_r && (id_r == key_in);
      cst_pkg::CMD_FREE:   qualify = valid_r && (id_r == key_in);
      default:             qualify = 1'b0;
    endcase
    hit = tok_in.vld && !tok_in.found && qualify;
  end

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    if (hit && tok_in.cmd == cst_pkg::CMD_ALLOC) begin
      // for allocate the key lane carries the freshly generated id
      valid_nxt = 1'b1;
      id_nxt    = key_in;
    end else if (hit && tok_in.cmd == cst_pkg::CMD_FREE) begin
      valid_nxt = 1'b0;
      id_nxt    = '0;
    end
    tok_nxt       = tok_in;
    tok_nxt.found = tok_in.found || hit;
    idx_nxt       = hit ? MY_IDX : idx_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      tok_r       <= '0;
    end else begin
      valid_r     <= valid_nxt;
      tok_r       <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    key_r       <= key_in;
    idx_r       <= idx_nxt;
  end

  assign tok_out = tok_r;
  assign key_out = key_r;
  assign idx_out = idx_r;

endmodule

// ===== hw/rtl/circuit_id_slot_table.sv =====
// ----------------------------------------------------------------------------
// circuit_id_slot_table: slot allocator with lookup by circuit id
// A row of slot cells; each request walks the row one cell per cycle, the
// lowest qualifying slot claims it, and the tail result updates the
// occupancy count and the id generator.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | tdata: cmd, circuit_id
//  out_    | master    | tdata: success, slot_index, assigned_id, used_count
//
//  An accepted request is registered into cell 0, then into each later cell in
//  turn, and the tail result is then registered into the result register.
//  A new request is taken when the result register is empty or being drained
//  in the same cycle, so no new request is taken while one walks the row.
//  Reset clears all slots, the count, and sets the generator to 1.
//  An unaccepted result holds; the row holds a valid token only while a request walks.
// ----------------------------------------------------------------------------
module circuit_id_slot_table #(
  parameter int SLOTS = cst_pkg::DEF_SLOTS,
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CNT_W    = $clog2(SLOTS + 1),
  localparam int IN_BITS  = cst_pkg::CMD_W + cst_pkg::ID_W,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 1 + IDX_W + cst_pkg::ID_W + CNT_W,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // cmd, circuit_id
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // success, slot_index, assigned_id, used_count
);

  cst_pkg::cst_state_t       state_r, state_nxt;
  logic [cst_pkg::ID_W-1:0]  next_id_r, next_id_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      succ_r, succ_nxt;
  logic [IDX_W-1:0]          sidx_r, sidx_nxt;
  logic [cst_pkg::ID_W-1:0]  held_r, held_nxt;

  cst_pkg::cst_tok_t         tok   [0:SLOTS];
  logic [cst_pkg::ID_W-1:0]  key   [0:SLOTS];
  logic [IDX_W-1:0]          idx   [0:SLOTS];

  logic                      in_acc;
  logic                      tail_vld;
  cst_pkg::cst_cmd_t         in_cmd;
  logic [cst_pkg::ID_W-1:0]  in_id;

  assign in_cmd   = cst_pkg::cst_cmd_t'(in_tdata[cst_pkg::CMD_W-1:0]);
  assign in_id    = in_tdata[cst_pkg::CMD_W +: cst_pkg::ID_W];
  assign in_acc   = in_tvalid && in_tready;
  assign tail_vld = tok[SLOTS].vld;

  // inject the request at the head of the row
  assign tok[0] = '{vld: in_acc, cmd: in_cmd, found: 1'b0};
  assign key[0] = (in_cmd == cst_pkg::CMD_ALLOC) ? next_id_r : in_id;
  assign idx[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    cst_cell #(
      .IDX_W   (IDX_W),
      .CELL_IDX(g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_in (tok[g]),
      .key_in (key[g]),
      .idx_in (idx[g]),
      .tok_out(tok[g+1]),
      .key_out(key[g+1]),
      .idx_out(idx[g+1])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cst_pkg::ST_IDLE: if (in_acc) state_nxt = cst_pkg::ST_RUN;
      cst_pkg::ST_RUN:  if (tail_vld) state_nxt = cst_pkg::ST_HOLD;
      cst_pkg::ST_HOLD: begin
        if (in_acc) state_nxt = cst_pkg::ST_RUN;
        else if (out_tready) state_nxt = cst_pkg::ST_IDLE;
      end
      default:          state_nxt = cst_pkg::ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_tready  = (state_r == cst_pkg::ST_IDLE) ||
                 ((state_r == cst_pkg::ST_HOLD) && out_tready);
    out_tvalid = (state_r == cst_pkg::ST_HOLD);
  end

  // retire the request leaving the tail
  always_comb begin
    next_id_nxt = next_id_r;
    cnt_nxt     = cnt_r;
    succ_nxt    = succ_r;
    sidx_nxt    = sidx_r;
    held_nxt    = held_r;
    if (tail_vld) begin
      succ_nxt = tok[SLOTS].found;
      sidx_nxt = tok[SLOTS].found ? idx[SLOTS] : '0;
      held_nxt = tok[SLOTS].found ? key[SLOTS] : '0;
      if (tok[SLOTS].found && tok[SLOTS].cmd == cst_pkg::CMD_ALLOC) begin
        next_id_nxt = next_id_r + 64'd1;
        cnt_nxt     = cnt_r + CNT_W'(1);
      end else if (tok[SLOTS].found && tok[SLOTS].cmd == cst_pkg::CMD_FREE) begin
        cnt_nxt     = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cst_pkg::ST_IDLE;
      next_id_r <= cst_pkg::ID_FIRST;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      next_id_r <= next_id_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    succ_r <= succ_nxt;
    sidx_r <= sidx_nxt;
    held_r <= held_nxt;
  end

  assign out_tdata = OUT_W'({cnt_r, held_r, sidx_r, succ_r});

endmodule
